### hdl/assert_macros.svh
// Assertion macros included by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");
// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

### hdl/wpid_pkg.sv
// Package: widths, register codes and types of the windowed PID block
`timescale 1ns / 1ps
package wpid_pkg;

  localparam int WINDOW    = 8;
  localparam int Q_FRAC    = 8;
  localparam int MEAS_W    = 16;
  localparam int E_W       = MEAS_W + 1;
  localparam int GAIN_W    = 16;
  localparam int TOT_W     = 24;
  localparam int SLOPE_W   = E_W + 1;
  localparam int CURV_W    = E_W + 2;
  localparam int OPND_W    = 36;
  localparam int PROD_W    = GAIN_W + OPND_W;
  localparam int ACC_W     = PROD_W + 1;
  localparam int BIAS_W    = E_W + Q_FRAC;
  localparam int CTRL_W    = 32;
  localparam int LVL_W     = CTRL_W + 2;
  localparam int PWM_W     = 16;
  localparam int MODE_W    = 2;
  localparam int STEP_W    = 2;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;
  localparam int IN_DW     = 16;
  localparam int OUT_DW    = 72;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(2);

  // mode codes
  localparam logic [MODE_W-1:0] MODE_POS  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INC  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PRED = 2'd2;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_SETPOINT = 3'd0;
  localparam logic [2:0] REG_GAIN_P   = 3'd1;
  localparam logic [2:0] REG_GAIN_I   = 3'd2;
  localparam logic [2:0] REG_GAIN_D   = 3'd3;
  localparam logic [2:0] REG_FB_GAIN  = 3'd4;
  localparam logic [2:0] REG_PRE_GAIN = 3'd5;
  localparam logic [2:0] REG_PWM_LIM  = 3'd6;
  localparam logic [2:0] REG_MODE     = 3'd7;

  typedef enum logic [1:0] {
    ACC_LOAD,
    ACC_ADD,
    ACC_LOAD_BIAS
  } acc_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_DRAIN,
    S_SAT,
    S_PWM
  } seq_state_t;

  typedef struct packed {
    logic              in_rdy;
    logic              prep;
    logic              mul;
    logic [STEP_W-1:0] step;
    logic              sat;
    logic              fin;
  } seq_ctl_t;

endpackage

### hdl/wpid_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulate
`timescale 1ns / 1ps
module wpid_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                issue,
  input  wpid_pkg::acc_op_t                   op,
  input  logic signed [wpid_pkg::GAIN_W-1:0]  gain,
  input  logic signed [wpid_pkg::OPND_W-1:0]  opnd,
  input  logic signed [wpid_pkg::BIAS_W-1:0]  bias,
  output logic signed [wpid_pkg::ACC_W-1:0]   acc
);
  import wpid_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [BIAS_W-1:0] bias_r;
  acc_op_t                  op_r;
  logic                     vld_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;

  assign prod_nxt = gain * opnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      prod_r <= prod_nxt;
      op_r   <= op;
      bias_r <= bias;
    end
  end

  always_comb begin
    unique case (op_r)
      ACC_LOAD:      acc_nxt = ACC_W'(prod_r);
      ACC_ADD:       acc_nxt = acc_r + ACC_W'(prod_r);
      ACC_LOAD_BIAS: acc_nxt = ACC_W'(prod_r) + ACC_W'(bias_r);
      default:       acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vld_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

### hdl/wpid_seq.sv
// Sequencer: walks one word through prepare, three MAC steps, drain, saturate, PWM
`timescale 1ns / 1ps
module wpid_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               out_free,
  output wpid_pkg::seq_ctl_t ctl
);
  import wpid_pkg::*;

  seq_state_t        state_r;
  seq_state_t        state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = '0;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_PREP;
      S_PREP:  state_nxt = S_MUL;
      S_MUL: begin
        if (step_r == STEP_LAST) begin
          state_nxt = S_DRAIN;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_DRAIN: state_nxt = S_SAT;
      S_SAT:   state_nxt = S_PWM;
      S_PWM:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.in_rdy = (state_r == S_IDLE);
    ctl.prep   = (state_r == S_PREP);
    ctl.mul    = (state_r == S_MUL);
    ctl.step   = step_r;
    ctl.sat    = (state_r == S_SAT);
    ctl.fin    = (state_r == S_PWM) && out_free;
  end

endmodule

### hdl/windowed_pid_with_pwm_accumulator.sv
// Top level: windowed PID controller with PWM accumulator
//
// Usage:
//  - Input stream (in_*): one measured sample per word, in_tdata[15:0].
//  - Output stream (out_*): one result word per sample carrying control_out,
//    pwm_level and error_now.
//  - Config port (cfg_*): APB-style, registers at byte address 4*index,
//    pready always high; write registers only while the block is idle.
//  - Timing: an accepted sample goes through a prepare state, the MAC steps
//    issuing into the shared 16x36 multiplier, a drain state, saturate, then
//    the PWM update and output load, and then shows up on out_tvalid.
//    in_tready is high only in the idle state, so the next sample is not
//    accepted until the current one has reached its PWM/output step.
//  - Reset (rst_n low, synchronous): error window, window total and PWM
//    level clear, registers take their defaults (pwm_limit 65535).
//  - Stall: the finished word sits in the output register; the next sample
//    is still accepted and processed, and only its final PWM/output step
//    waits until out_tready frees the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module windowed_pid_with_pwm_accumulator (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: [15:0] measured
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [wpid_pkg::IN_DW-1:0]     in_tdata,
  // out_tdata: [31:0] control_out, [47:32] pwm_level, [64:48] error_now, zero pad
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [wpid_pkg::OUT_DW-1:0]    out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [wpid_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [wpid_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [wpid_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                           cfg_pready
);
  import wpid_pkg::*;

  // config registers
  logic signed [GAIN_W-1:0] setpoint_r;
  logic signed [GAIN_W-1:0] gp_r;
  logic signed [GAIN_W-1:0] gi_r;
  logic signed [GAIN_W-1:0] gd_r;
  logic signed [GAIN_W-1:0] fb_r;
  logic signed [GAIN_W-1:0] pk_r;
  logic [PWM_W-1:0]         limit_r;
  logic [MODE_W-1:0]        mode_r;
  logic                     cfg_wr;
  logic [2:0]               cfg_idx;

  // datapath state
  logic signed [MEAS_W-1:0]  meas_r;
  logic signed [E_W-1:0]     win_r [WINDOW+1];
  logic signed [TOT_W-1:0]   total_r;
  logic signed [E_W-1:0]     e_r;
  logic signed [SLOPE_W-1:0] slope_r;
  logic signed [CURV_W-1:0]  curv_r;
  logic signed [CTRL_W-1:0]  ctrl_r;
  logic [PWM_W-1:0]          pwm_r;
  logic signed [E_W-1:0]     e_nxt;

  // output register
  logic                      out_valid_r;
  logic signed [CTRL_W-1:0]  out_ctrl_r;
  logic [PWM_W-1:0]          out_pwm_r;
  logic signed [E_W-1:0]     out_err_r;

  seq_ctl_t                  ctl;
  logic                      in_fire;
  logic                      out_free;

  logic                      issue;
  acc_op_t                   op;
  logic signed [GAIN_W-1:0]  gain;
  logic signed [OPND_W-1:0]  opnd;
  logic signed [BIAS_W-1:0]  bias;
  logic signed [ACC_W-1:0]   acc;

  logic signed [ACC_W-1:0]   shifted;
  logic [ACC_W-CTRL_W:0]     hi_bits;
  logic signed [CTRL_W-1:0]  sat_val;

  logic signed [LVL_W-1:0]   lvl;
  logic signed [LVL_W-1:0]   lim_ext;
  logic [PWM_W-1:0]          pwm_mid;
  logic [PWM_W-1:0]          pwm_new;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= '0;
      gp_r       <= '0;
      gi_r       <= '0;
      gd_r       <= '0;
      fb_r       <= '0;
      pk_r       <= '0;
      limit_r    <= '1;
      mode_r     <= MODE_POS;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SETPOINT: setpoint_r <= cfg_pwdata[GAIN_W-1:0];
        REG_GAIN_P:   gp_r       <= cfg_pwdata[GAIN_W-1:0];
        REG_GAIN_I:   gi_r       <= cfg_pwdata[GAIN_W-1:0];
        REG_GAIN_D:   gd_r       <= cfg_pwdata[GAIN_W-1:0];
        REG_FB_GAIN:  fb_r       <= cfg_pwdata[GAIN_W-1:0];
        REG_PRE_GAIN: pk_r       <= cfg_pwdata[GAIN_W-1:0];
        REG_PWM_LIM:  limit_r    <= cfg_pwdata[PWM_W-1:0];
        REG_MODE:     mode_r     <= cfg_pwdata[MODE_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SETPOINT: cfg_prdata = {{(CFG_DW-GAIN_W){1'b0}}, setpoint_r};
      REG_GAIN_P:   cfg_prdata = {{(CFG_DW-GAIN_W){1'b0}}, gp_r};
      REG_GAIN_I:   cfg_prdata = {{(CFG_DW-GAIN_W){1'b0}}, gi_r};
      REG_GAIN_D:   cfg_prdata = {{(CFG_DW-GAIN_W){1'b0}}, gd_r};
      REG_FB_GAIN:  cfg_prdata = {{(CFG_DW-GAIN_W){1'b0}}, fb_r};
      REG_PRE_GAIN: cfg_prdata = {{(CFG_DW-GAIN_W){1'b0}}, pk_r};
      REG_PWM_LIM:  cfg_prdata = {{(CFG_DW-PWM_W){1'b0}}, limit_r};
      REG_MODE:     cfg_prdata = {{(CFG_DW-MODE_W){1'b0}}, mode_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  assign in_tready = ctl.in_rdy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  wpid_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .ctl      (ctl)
  );

  // ---------------- error window ----------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      meas_r <= in_tdata[MEAS_W-1:0];
    end
  end

  assign e_nxt = E_W'(setpoint_r) - E_W'(meas_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= WINDOW; i++) begin
        win_r[i] <= '0;
      end
      total_r <= '0;
    end else if (ctl.prep) begin
      for (int i = 0; i < WINDOW; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[WINDOW] <= e_nxt;
      total_r       <= total_r - TOT_W'(win_r[0]) + TOT_W'(e_nxt);
    end
  end

  // slope and curvature use the window taps before the shift
  always_ff @(posedge clk) begin
    if (ctl.prep) begin
      e_r     <= e_nxt;
      slope_r <= SLOPE_W'(e_nxt) - SLOPE_W'(win_r[WINDOW]);
      curv_r  <= CURV_W'(e_nxt) - (CURV_W'(win_r[WINDOW]) <<< 1)
                 + CURV_W'(win_r[WINDOW-1]);
    end
  end

  // ---------------- MAC operand select ----------------
  assign bias = {e_r, {Q_FRAC{1'b0}}};

  always_comb begin
    issue = 1'b0;
    op    = ACC_LOAD;
    gain  = gp_r;
    opnd  = '0;
    unique case (mode_r)
      MODE_POS: begin
        issue = ctl.mul;
        unique case (ctl.step)
          2'd0:    begin op = ACC_LOAD; gain = gp_r; opnd = OPND_W'(e_r);     end
          2'd1:    begin op = ACC_ADD;  gain = gi_r; opnd = OPND_W'(total_r); end
          default: begin op = ACC_ADD;  gain = gd_r; opnd = OPND_W'(slope_r); end
        endcase
      end
      MODE_INC: begin
        issue = ctl.mul;
        unique case (ctl.step)
          2'd0:    begin op = ACC_LOAD; gain = gp_r; opnd = OPND_W'(slope_r); end
          2'd1:    begin op = ACC_ADD;  gain = gi_r; opnd = OPND_W'(e_r);     end
          default: begin op = ACC_ADD;  gain = gd_r; opnd = OPND_W'(curv_r);  end
        endcase
      end
      MODE_PRED: begin
        // step 1 is a bubble so that the inner term lands in acc first
        unique case (ctl.step)
          2'd0: begin
            issue = ctl.mul;
            op    = ACC_LOAD_BIAS;
            gain  = pk_r;
            opnd  = OPND_W'(slope_r);
          end
          2'd1: issue = 1'b0;
          default: begin
            issue = ctl.mul;
            op    = ACC_LOAD;
            gain  = fb_r;
            opnd  = acc[OPND_W-1:0];
          end
        endcase
      end
      default: issue = 1'b0;
    endcase
  end

  wpid_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (issue),
    .op    (op),
    .gain  (gain),
    .opnd  (opnd),
    .bias  (bias),
    .acc   (acc)
  );

  // ---------------- floor shift and saturate ----------------
  assign shifted = (mode_r == MODE_PRED) ? (acc >>> (2 * Q_FRAC)) : (acc >>> Q_FRAC);
  assign hi_bits = shifted[ACC_W-1:CTRL_W-1];

  always_comb begin
    if ((&hi_bits) || !(|hi_bits)) begin
      sat_val = shifted[CTRL_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat_val = {1'b1, {(CTRL_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(CTRL_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sat) begin
      if (mode_r == MODE_POS || mode_r == MODE_INC || mode_r == MODE_PRED) begin
        ctrl_r <= sat_val;
      end else begin
        ctrl_r <= '0;
      end
    end
  end

  // ---------------- PWM accumulate ----------------
  assign lvl     = LVL_W'($signed({1'b0, pwm_r})) + LVL_W'(ctrl_r);
  assign lim_ext = LVL_W'($signed({1'b0, limit_r}));

  always_comb begin
    pwm_mid = pwm_r;
    if (ctrl_r > 0) begin
      if (lvl <= lim_ext) pwm_mid = lvl[PWM_W-1:0];
    end else begin
      if (lvl >= 0) pwm_mid = lvl[PWM_W-1:0];
    end
    if (mode_r == MODE_INC) begin
      pwm_new = (pwm_mid > limit_r) ? limit_r : pwm_mid;
    end else begin
      pwm_new = pwm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_r <= '0;
    end else if (ctl.fin) begin
      pwm_r <= pwm_new;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      out_ctrl_r <= ctrl_r;
      out_pwm_r  <= pwm_new;
      out_err_r  <= e_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DW-CTRL_W-PWM_W-E_W){1'b0}}, out_err_r, out_pwm_r, out_ctrl_r};

  // ---------------- assertions ----------------
  `ASSERT_NEXT(a_busy_after_accept, in_fire, !in_tready)
  `ASSERT_NEXT(a_pwm_hold_other_modes, mode_r != MODE_INC && !cfg_wr, $stable(pwm_r))
  `ASSERT_NEXT(a_pwm_within_limit, ctl.fin && mode_r == MODE_INC && !cfg_wr, pwm_r <= limit_r)
  `ASSERT_IMPL(a_fin_needs_room, ctl.fin, !out_valid_r || out_tready)

endmodule

### verif/testbench.sv
// Self-checking testbench for the windowed PID controller with PWM accumulator
`timescale 1ns / 1ps
module testbench;
  import wpid_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic signed [15:0] S_MIN = 16'sh8000;
  localparam logic signed [15:0] S_MAX = 16'sh7FFF;
  localparam int RANDOM_SAMPLES = 1750;
  localparam int QUIET_TAIL     = 250;
  localparam int LONG_HOLD      = 200;
  localparam int DRAIN_CYCLES   = 16;
  localparam int CYCLE_LIMIT    = 400000;

  typedef struct packed {
    logic [CTRL_W-1:0] ctrl;
    logic [PWM_W-1:0]  pwm;
    logic [E_W-1:0]    err;
  } pid_result_t;

  // Tracks controller state and predicts one result word per accepted sample
  class pid_scoreboard;
    logic signed [GAIN_W-1:0] setpoint, gain_p, gain_i, gain_d, fb_gain, pre_gain;
    logic [PWM_W-1:0]         pwm_limit;
    logic [MODE_W-1:0]        mode;
    logic signed [E_W-1:0]    err_hist [0:WINDOW];
    logic signed [TOT_W-1:0]  err_sum;
    logic [PWM_W-1:0]         pwm_level;
    pid_result_t              expected_q[$];
    int                       mismatches;
    int                       results_checked;

    function new();
      setpoint  = '0;
      gain_p    = '0;
      gain_i    = '0;
      gain_d    = '0;
      fb_gain   = '0;
      pre_gain  = '0;
      pwm_limit = 16'hFFFF;
      mode      = MODE_POS;
      foreach (err_hist[i]) err_hist[i] = '0;
      err_sum   = '0;
      pwm_level = '0;
      mismatches = 0;
      results_checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        REG_SETPOINT: setpoint  = val[15:0];
        REG_GAIN_P:   gain_p    = val[15:0];
        REG_GAIN_I:   gain_i    = val[15:0];
        REG_GAIN_D:   gain_d    = val[15:0];
        REG_FB_GAIN:  fb_gain   = val[15:0];
        REG_PRE_GAIN: pre_gain  = val[15:0];
        REG_PWM_LIM:  pwm_limit = val[15:0];
        REG_MODE:     mode      = val[MODE_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void take_sample(logic signed [MEAS_W-1:0] meas);
      longint e, slope, curv, acc, ctrl, lvl, inner;
      pid_result_t r;
      e = setpoint - meas;
      err_sum = TOT_W'(err_sum - err_hist[0] + e);
      for (int i = 0; i < WINDOW; i++) err_hist[i] = err_hist[i+1];
      err_hist[WINDOW] = E_W'(e);
      slope = e - err_hist[WINDOW-1];
      curv  = e - 2 * err_hist[WINDOW-1] + err_hist[WINDOW-2];
      ctrl  = 0;
      case (mode)
        MODE_POS: begin
          acc  = gain_p * e + gain_i * err_sum + gain_d * slope;
          ctrl = clip32(acc >>> Q_FRAC);
        end
        MODE_INC: begin
          acc  = gain_p * slope + gain_i * e + gain_d * curv;
          ctrl = clip32(acc >>> Q_FRAC);
          lvl  = longint'(pwm_level) + ctrl;
          // level moves only when the new value stays in range
          if (ctrl > 0) begin
            if (lvl <= longint'(pwm_limit)) pwm_level = lvl[15:0];
          end else if (lvl >= 0) begin
            pwm_level = lvl[15:0];
          end
          if (pwm_level > pwm_limit) pwm_level = pwm_limit;
        end
        MODE_PRED: begin
          inner = e * 256 + slope * pre_gain;
          acc   = fb_gain * inner;
          ctrl  = clip32(acc >>> (2 * Q_FRAC));
        end
        default: ctrl = 0;
      endcase
      r.ctrl = ctrl[31:0];
      r.pwm  = pwm_level;
      r.err  = e[E_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [OUT_DW-1:0] word);
      pid_result_t r;
      if (expected_q.size() == 0) begin
        $error("result word %h arrived with no sample pending", word);
        mismatches++;
        return;
      end
      r = expected_q.pop_front();
      results_checked++;
      if (word[31:0] !== r.ctrl) begin
        $error("control_out mismatch: expected %0d, actual %0d",
               $signed(r.ctrl), $signed(word[31:0]));
        mismatches++;
      end
      if (word[47:32] !== r.pwm) begin
        $error("pwm_level mismatch: expected %0d, actual %0d", r.pwm, word[47:32]);
        mismatches++;
      end
      if (word[64:48] !== r.err) begin
        $error("error_now mismatch: expected %0d, actual %0d",
               $signed(r.err), $signed(word[64:48]));
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_DW-1:0]   out_tdata;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  pid_scoreboard sb = new();
  bit idling   = 1'b1;
  bit hold_req = 1'b0;
  int samples_sent = 0;
  int settings_run = 0;

  windowed_pid_with_pwm_accumulator i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("windowed_pid_with_pwm_accumulator test failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // result side: random short stalls, plus one long hold on request
  initial begin : result_sink
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_tready <= 1'b1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic [15:0] rnd16();
    logic [31:0] r;
    r = $urandom();
    return r[15:0];
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [CFG_DW-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_config(input logic signed [15:0] sp, kp, ki, kd, fb, pk,
                            input logic [15:0] lim, input logic [MODE_W-1:0] md);
    cfg_write(REG_SETPOINT, {16'h0000, sp});
    cfg_write(REG_GAIN_P,   {16'h0000, kp});
    cfg_write(REG_GAIN_I,   {16'h0000, ki});
    cfg_write(REG_GAIN_D,   {16'h0000, kd});
    cfg_write(REG_FB_GAIN,  {16'h0000, fb});
    cfg_write(REG_PRE_GAIN, {16'h0000, pk});
    cfg_write(REG_PWM_LIM,  {16'h0000, lim});
    cfg_write(REG_MODE,     {30'd0, md});
    settings_run++;
  endtask

  task automatic send_sample(input logic signed [MEAS_W-1:0] meas);
    in_tvalid <= 1'b1;
    in_tdata  <= meas;
    do @(posedge clk); while (!in_tready);
    sb.take_sample(meas);
    samples_sent++;
    if (idling && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // sender pauses here until every predicted word has been checked
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_gain(input bit tame);
    int g;
    case ($urandom_range(0, 7))
      0: return S_MIN;
      1: return S_MAX;
      default: begin
        if (!tame) return rnd16();
        g = int'($urandom_range(0, 1024)) - 512;
        return g[15:0];
      end
    endcase
  endfunction

  task automatic random_phase(input int n_items, input bit tame, input bit long_hold);
    logic signed [15:0] sp;
    logic [15:0]        lim;
    logic [MODE_W-1:0]  md;
    int                 span, v, k;
    if (tame) begin
      v  = int'($urandom_range(0, 8000)) - 4000;
      sp = v[15:0];
    end else begin
      case ($urandom_range(0, 3))
        0: sp = S_MIN;
        1: sp = S_MAX;
        default: sp = rnd16();
      endcase
    end
    case ($urandom_range(0, 7))
      0: lim = 16'h0000;
      1: lim = 16'h0001;
      2: lim = 16'hFFFF;
      default: lim = rnd16();
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2:    md = MODE_POS;
      3, 4, 5, 6: md = MODE_INC;
      7, 8:       md = MODE_PRED;
      default:    md = MODE_UNUSED;
    endcase
    set_config(sp, rand_gain(tame), rand_gain(tame), rand_gain(tame),
               rand_gain(tame), rand_gain(tame), lim, md);
    case ($urandom_range(0, 2))
      0: span = 16;
      1: span = 256;
      default: span = 4096;
    endcase
    if (long_hold) hold_req = 1'b1;
    for (k = 0; k < n_items; k++) begin
      if (tame && $urandom_range(0, 15) != 0) begin
        // samples wander around the setpoint like a settling loop
        v = int'(sp) + int'($urandom_range(0, 2 * span)) - span;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        send_sample(v[15:0]);
      end else begin
        send_sample(rnd16());
      end
    end
    wait_drained();
  endtask

  initial begin : stimulus
    int random_sent, n, phase;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: zero gains, only the error field moves
    send_sample(S_MIN);
    send_sample(S_MAX);
    wait_drained();
    // largest positive error repeatedly, then zero error
    set_config(S_MAX, S_MAX, S_MAX, S_MAX, 16'sd0, 16'sd0, 16'hFFFF, MODE_POS);
    repeat (3) send_sample(S_MIN);
    send_sample(S_MAX);
    wait_drained();
    set_config(S_MIN, S_MIN, S_MIN, S_MIN, 16'sd0, 16'sd0, 16'hFFFF, MODE_POS);
    send_sample(S_MAX);
    wait_drained();
    // full-scale error swing saturates the predictive output both ways
    set_config(S_MAX, 16'sd0, 16'sd0, 16'sd0, S_MAX, S_MAX, 16'hFFFF, MODE_PRED);
    send_sample(S_MIN);
    wait_drained();
    set_config(S_MIN, 16'sd0, 16'sd0, 16'sd0, S_MAX, S_MAX, 16'hFFFF, MODE_PRED);
    send_sample(S_MAX);
    wait_drained();
    set_config(S_MAX, 16'sd0, 16'sd0, 16'sd0, S_MIN, S_MAX, 16'hFFFF, MODE_PRED);
    send_sample(S_MIN);
    wait_drained();
    // unity integral gain: delta equals error; over-limit and below-zero holds
    set_config(16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'd1000, MODE_INC);
    send_sample(-16'sd500);
    send_sample(-16'sd600);
    send_sample(-16'sd500);
    send_sample(16'sd700);
    send_sample(16'sd400);
    send_sample(16'sd300);
    send_sample(16'sd0);
    send_sample(-16'sd800);
    wait_drained();
    // limit lowered under the current level forces a clamp
    set_config(16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'd100, MODE_INC);
    send_sample(16'sd0);
    wait_drained();
    set_config(16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'd0, MODE_INC);
    send_sample(-16'sd5);
    wait_drained();
    set_config(16'sd100, S_MAX, 16'sd128, S_MIN, S_MAX, S_MIN, 16'd500, MODE_UNUSED);
    send_sample(16'sd1234);
    wait_drained();

    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_SAMPLES) begin
      idling = (RANDOM_SAMPLES - random_sent > QUIET_TAIL);
      n = $urandom_range(40, 120);
      random_phase(n, $urandom_range(0, 2) != 0, phase == 3);
      random_sent += n;
      phase++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d samples sent, %0d result words checked across %0d register settings",
             samples_sent, sb.results_checked, settings_run);
    $display("covered all four modes, saturation, PWM holds/clamps and output back-pressure");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("windowed_pid_with_pwm_accumulator test passed");
    end else begin
      $display("windowed_pid_with_pwm_accumulator test failed");
    end
    $finish;
  end

endmodule

### windowed_pid_with_pwm_accumulator.f
+incdir+hdl
hdl/wpid_pkg.sv
hdl/wpid_mac.sv
hdl/wpid_seq.sv
hdl/windowed_pid_with_pwm_accumulator.sv
verif/testbench.sv
